[hw/rtl/vlpr_pkg.sv]
// Shared constants, types and helper functions for the variable-length packet ring.
// Used by vlpr_wr_ctrl and the top level; has no dependencies of its own.
`default_nettype none

package vlpr_pkg;

    // Ring geometry
    localparam int SLOT_COUNT = 16;
    localparam int SLOT_BYTES = 64;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int ST_W   = 3;
    localparam int OCC_W  = 4;
    localparam int REJ_W  = 2;

    // Derived widths
    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int SLOT_CW   = SLOT_W + 1;
    localparam int OFF_W     = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int PKT_DEPTH = SLOT_COUNT * SLOT_BYTES;
    localparam int ADDR_W    = $clog2(PKT_DEPTH);

    // Commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_READ   = 3'd0;
    localparam logic [ST_W-1:0] ST_ACCEPT = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
    localparam logic [ST_W-1:0] ST_LONG   = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY  = 3'd4;
    localparam logic [ST_W-1:0] ST_DROP   = 3'd5;

    // Rejection state of the packet being written
    localparam logic [REJ_W-1:0] REJ_NONE = 2'd0;
    localparam logic [REJ_W-1:0] REJ_FULL = 2'd1;
    localparam logic [REJ_W-1:0] REJ_LONG = 2'd2;

    // Write-side decision for one write byte
    typedef struct packed {
        logic                  store_en;
        logic [ADDR_W-1:0]     store_addr;
        logic [BYTE_W-1:0]     store_data;
        logic                  commit;
        logic [LEN_W-1:0]      length;
        logic [ST_W-1:0]       status;
    } t_wr_result;

    // Advance a slot index with wrap
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        if (s == SLOT_W'(SLOT_COUNT - 1)) begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    // Byte address of an offset within a slot
    function automatic logic [ADDR_W-1:0] pkt_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [OFF_W-1:0]  off);
        return ADDR_W'(slot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(off);
    endfunction

    // Packets held, reported in the low bits
    function automatic logic [OCC_W-1:0] occupancy(input logic [SLOT_W-1:0] ws,
                                                   input logic [SLOT_W-1:0] rs);
        logic [SLOT_CW-1:0] d;
        if (ws >= rs) begin
            d = {1'b0, ws} - {1'b0, rs};
        end else begin
            d = {1'b0, ws} + SLOT_CW'(SLOT_COUNT) - {1'b0, rs};
        end
        return OCC_W'(d);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/vlpr_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module vlpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hw/rtl/vlpr_wr_ctrl.sv]
// Write-side packet tracking: byte count and sticky rejection of the packet in progress.
// Depends on vlpr_pkg.
`default_nettype none

module vlpr_wr_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_fire,
    input  wire logic                           i_clear,
    input  wire logic [vlpr_pkg::BYTE_W-1:0]    i_data,
    input  wire logic                           i_last,
    input  wire logic [vlpr_pkg::SLOT_W-1:0]    i_write_slot,
    input  wire logic [vlpr_pkg::SLOT_W-1:0]    i_read_slot,
    output vlpr_pkg::t_wr_result                o_result
);

    logic [vlpr_pkg::LEN_W-1:0] r_bytes;
    logic [vlpr_pkg::LEN_W-1:0] n_bytes;
    logic [vlpr_pkg::REJ_W-1:0] r_rejected;
    logic [vlpr_pkg::REJ_W-1:0] n_rejected;
    logic [vlpr_pkg::REJ_W-1:0] w_rej_now;
    logic                       w_store;
    logic [vlpr_pkg::LEN_W-1:0] w_bytes_inc;

    // Decide full / too long / store for this byte
    always_comb begin
        w_rej_now   = r_rejected;
        w_store     = 1'b0;
        w_bytes_inc = r_bytes;
        if (r_bytes == '0 && r_rejected == vlpr_pkg::REJ_NONE &&
            vlpr_pkg::next_slot(i_write_slot) == i_read_slot) begin
            w_rej_now = vlpr_pkg::REJ_FULL;
        end
        if (w_rej_now == vlpr_pkg::REJ_NONE) begin
            if (r_bytes >= vlpr_pkg::LEN_W'(vlpr_pkg::SLOT_BYTES)) begin
                w_rej_now = vlpr_pkg::REJ_LONG;
            end else begin
                w_store     = 1'b1;
                w_bytes_inc = r_bytes + 1'b1;
            end
        end
    end

    // Build the result for the top level
    always_comb begin
        o_result.store_en   = i_fire && w_store;
        o_result.store_addr = vlpr_pkg::pkt_addr(i_write_slot,
                                                 r_bytes[vlpr_pkg::OFF_W-1:0]);
        o_result.store_data = i_data;
        o_result.commit     = i_last && (w_rej_now == vlpr_pkg::REJ_NONE);
        o_result.length     = w_bytes_inc;
        case (w_rej_now)
            vlpr_pkg::REJ_FULL: o_result.status = vlpr_pkg::ST_FULL;
            vlpr_pkg::REJ_LONG: o_result.status = vlpr_pkg::ST_LONG;
            default:            o_result.status = vlpr_pkg::ST_ACCEPT;
        endcase
    end

    // Advance packet state; clear on the last byte or an index reset
    always_comb begin
        n_bytes    = r_bytes;
        n_rejected = r_rejected;
        if (i_clear) begin
            n_bytes    = '0;
            n_rejected = vlpr_pkg::REJ_NONE;
        end else if (i_fire) begin
            if (i_last) begin
                n_bytes    = '0;
                n_rejected = vlpr_pkg::REJ_NONE;
            end else begin
                n_bytes    = w_bytes_inc;
                n_rejected = w_rej_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes    <= '0;
            r_rejected <= vlpr_pkg::REJ_NONE;
        end else begin
            r_bytes    <= n_bytes;
            r_rejected <= n_rejected;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/variable_length_packet_ring_top.sv]
// Top level of the variable-length packet ring: slot indices, read sequencer,
// output register, and the packet and length memories. Depends on vlpr_pkg,
// vlpr_ram and vlpr_wr_ctrl.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one command per transaction:
//   write byte, read packet request, or reset indices. Output channel
//   (o_out_valid / i_out_stall) delivers result transactions from a register.
//   Write byte: one result, loaded into the output register at the accepting
//   edge; writes are taken every cycle while the output side keeps up.
//   Read request: an empty ring answers at once. Otherwise the slot length is
//   fetched from the length memory, then a drop result, or the packet bytes
//   one per cycle while the receiver keeps up, from the packet memory, whose
//   registered read data feeds the output register. A read holds the input
//   side until its drop result or last byte is loaded.
//   Reset indices and the unused command give no result.
//   When the receiver stalls, the output register holds and the read
//   sequencer pauses; the packet memory read data holds until it is taken.
//   Reset clears indices, packet-in-progress state and the output valid; the
//   memories keep their contents and need no clearing pass.
`default_nettype none

module variable_length_packet_ring_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [vlpr_pkg::CMD_W-1:0]  i_cmd,
    input  wire logic [vlpr_pkg::BYTE_W-1:0] i_data_byte,
    input  wire logic                        i_last_byte,
    input  wire logic [vlpr_pkg::LEN_W-1:0]  i_read_limit,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [vlpr_pkg::ST_W-1:0]   o_status,
    output logic      [vlpr_pkg::BYTE_W-1:0] o_out_byte,
    output logic                             o_end_of_run,
    output logic      [vlpr_pkg::LEN_W-1:0]  o_packet_length,
    output logic      [vlpr_pkg::OCC_W-1:0]  o_occupancy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LEN    = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [vlpr_pkg::SLOT_W-1:0]    r_write_slot;
    logic [vlpr_pkg::SLOT_W-1:0]    n_write_slot;
    logic [vlpr_pkg::SLOT_W-1:0]    r_read_slot;
    logic [vlpr_pkg::SLOT_W-1:0]    n_read_slot;
    logic [vlpr_pkg::SLOT_W-1:0]    r_head;
    logic [vlpr_pkg::SLOT_W-1:0]    n_head;
    logic [vlpr_pkg::LEN_W-1:0]     r_limit;
    logic [vlpr_pkg::LEN_W-1:0]     n_limit;
    logic [vlpr_pkg::LEN_W-1:0]     r_len;
    logic [vlpr_pkg::LEN_W-1:0]     n_len;
    logic [vlpr_pkg::OFF_W-1:0]     r_idx;
    logic [vlpr_pkg::OFF_W-1:0]     n_idx;

    logic                           r_out_valid;
    logic [vlpr_pkg::ST_W-1:0]      r_status;
    logic [vlpr_pkg::BYTE_W-1:0]    r_out_byte;
    logic                           r_end_of_run;
    logic [vlpr_pkg::LEN_W-1:0]     r_packet_length;
    logic [vlpr_pkg::OCC_W-1:0]     r_occupancy;

    logic                           w_out_free;
    logic                           w_accept;
    logic                           w_out_load;
    logic [vlpr_pkg::ST_W-1:0]      w_status;
    logic [vlpr_pkg::BYTE_W-1:0]    w_out_byte;
    logic                           w_end_of_run;
    logic [vlpr_pkg::LEN_W-1:0]     w_packet_length;
    logic [vlpr_pkg::OCC_W-1:0]     w_occupancy;

    logic                           w_wr_fire;
    logic                           w_wr_clear;
    vlpr_pkg::t_wr_result           w_wr;

    logic                           w_len_rd_en;
    logic [vlpr_pkg::LEN_W-1:0]     w_len_q;
    logic [vlpr_pkg::LEN_W-1:0]     w_len_clamp;
    logic                           w_drop;
    logic                           w_pkt_rd_en;
    logic [vlpr_pkg::ADDR_W-1:0]    w_pkt_rd_addr;
    logic [vlpr_pkg::BYTE_W-1:0]    w_pkt_q;
    logic                           w_last_idx;

    // Handshake on the input side
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Head-slot length as read, clamped to the slot size
    assign w_len_clamp = (w_len_q > vlpr_pkg::LEN_W'(vlpr_pkg::SLOT_BYTES)) ?
                         vlpr_pkg::LEN_W'(vlpr_pkg::SLOT_BYTES) : w_len_q;
    assign w_drop      = (w_len_clamp > r_limit) || (w_len_clamp == '0);
    assign w_last_idx  = (vlpr_pkg::LEN_W'(r_idx) + 1'b1) == r_len;

    // Sequence commands and read streaming
    always_comb begin
        n_state         = r_state;
        n_write_slot    = r_write_slot;
        n_read_slot     = r_read_slot;
        n_head          = r_head;
        n_limit         = r_limit;
        n_len           = r_len;
        n_idx           = r_idx;
        w_out_load      = 1'b0;
        w_status        = vlpr_pkg::ST_READ;
        w_out_byte      = '0;
        w_end_of_run    = 1'b1;
        w_packet_length = '0;
        w_occupancy     = vlpr_pkg::occupancy(r_write_slot, r_read_slot);
        w_wr_fire       = 1'b0;
        w_wr_clear      = 1'b0;
        w_len_rd_en     = 1'b0;
        w_pkt_rd_en     = 1'b0;
        w_pkt_rd_addr   = vlpr_pkg::pkt_addr(r_head, r_idx);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd)
                        vlpr_pkg::CMD_WRITE: begin
                            w_wr_fire  = 1'b1;
                            if (w_wr.commit) begin
                                n_write_slot = vlpr_pkg::next_slot(r_write_slot);
                            end
                            w_out_load  = 1'b1;
                            w_status    = w_wr.status;
                            w_occupancy = vlpr_pkg::occupancy(n_write_slot, r_read_slot);
                        end
                        vlpr_pkg::CMD_READ: begin
                            if (r_write_slot == r_read_slot) begin
                                w_out_load = 1'b1;
                                w_status   = vlpr_pkg::ST_EMPTY;
                            end else begin
                                w_len_rd_en = 1'b1;
                                n_head      = r_read_slot;
                                n_read_slot = vlpr_pkg::next_slot(r_read_slot);
                                n_limit     = i_read_limit;
                                n_state     = S_LEN;
                            end
                        end
                        vlpr_pkg::CMD_CLEAR: begin
                            n_write_slot = '0;
                            n_read_slot  = '0;
                            w_wr_clear   = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LEN: begin
                if (w_drop) begin
                    if (w_out_free) begin
                        w_out_load = 1'b1;
                        w_status   = vlpr_pkg::ST_DROP;
                        n_state    = S_IDLE;
                    end
                end else begin
                    // Fetch the first byte of the head slot
                    n_len         = w_len_clamp;
                    n_idx         = '0;
                    w_pkt_rd_en   = 1'b1;
                    w_pkt_rd_addr = vlpr_pkg::pkt_addr(r_head, '0);
                    n_state       = S_STREAM;
                end
            end
            S_STREAM: begin
                if (w_out_free) begin
                    w_out_load      = 1'b1;
                    w_status        = vlpr_pkg::ST_READ;
                    w_out_byte      = w_pkt_q;
                    w_end_of_run    = w_last_idx;
                    w_packet_length = r_len;
                    if (w_last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx         = r_idx + 1'b1;
                        w_pkt_rd_en   = 1'b1;
                        w_pkt_rd_addr = vlpr_pkg::pkt_addr(r_head, r_idx + 1'b1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_write_slot <= '0;
            r_read_slot  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_write_slot <= n_write_slot;
            r_read_slot  <= n_read_slot;
            r_out_valid  <= w_out_load || (r_out_valid && i_out_stall);
        end
    end

    // Read sequencer payload
    always_ff @(posedge i_clk) begin
        r_head  <= n_head;
        r_limit <= n_limit;
        r_len   <= n_len;
        r_idx   <= n_idx;
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_status        <= w_status;
            r_out_byte      <= w_out_byte;
            r_end_of_run    <= w_end_of_run;
            r_packet_length <= w_packet_length;
            r_occupancy     <= w_occupancy;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_out_byte      = r_out_byte;
    assign o_end_of_run    = r_end_of_run;
    assign o_packet_length = r_packet_length;
    assign o_occupancy     = r_occupancy;

    vlpr_wr_ctrl u_wr_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_wr_fire),
        .i_clear      (w_wr_clear),
        .i_data       (i_data_byte),
        .i_last       (i_last_byte),
        .i_write_slot (r_write_slot),
        .i_read_slot  (r_read_slot),
        .o_result     (w_wr)
    );

    vlpr_ram #(
        .WIDTH (vlpr_pkg::BYTE_W),
        .DEPTH (vlpr_pkg::PKT_DEPTH)
    ) u_packet_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr.store_en),
        .i_wr_addr (w_wr.store_addr),
        .i_wr_data (w_wr.store_data),
        .i_rd_en   (w_pkt_rd_en),
        .i_rd_addr (w_pkt_rd_addr),
        .o_rd_data (w_pkt_q)
    );

    vlpr_ram #(
        .WIDTH (vlpr_pkg::LEN_W),
        .DEPTH (vlpr_pkg::SLOT_COUNT)
    ) u_slot_lengths (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_fire && w_wr.commit),
        .i_wr_addr (r_write_slot),
        .i_wr_data (w_wr.length),
        .i_rd_en   (w_len_rd_en),
        .i_rd_addr (r_read_slot),
        .o_rd_data (w_len_q)
    );

    // Commands are taken only by the idle sequencer
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> r_state == S_IDLE)
        else $error("command accepted while a read is in progress");

    // Streamed bytes carry a length within the slot size
    a_read_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == vlpr_pkg::ST_READ) |->
        (o_packet_length != '0 &&
         o_packet_length <= vlpr_pkg::LEN_W'(vlpr_pkg::SLOT_BYTES)))
        else $error("read byte with bad packet length");

    // Indices hold while a packet streams out
    a_stream_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM && $past(r_state) == S_STREAM) |->
        ($stable(r_read_slot) && $stable(r_write_slot)))
        else $error("slot index moved during streaming");

    // Status code stays within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= vlpr_pkg::ST_DROP)
        else $error("undefined status code");

endmodule

`default_nettype wire
